/* hdl/clru_pkg.sv */
// ----------------------------------------------------------------------------
// clru_pkg: shared definitions for the true-LRU replacement core
// Field widths, stream packing and operation codes.
// ----------------------------------------------------------------------------
package clru_pkg;

    // request fields
    localparam int OP_W      = 1;
    localparam int SET_IDX_W = 6;
    localparam int WAY_IN_W  = 2;
    localparam int VICTIM_W  = 2;

    // stream packing (tdata padded to whole bytes)
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 8;

    localparam int SET_LSB   = 0;
    localparam int WAY_LSB   = SET_LSB + SET_IDX_W;
    localparam int LV_BIT    = WAY_LSB + WAY_IN_W;

    // number of distinct set_index codes
    localparam int IDX_CODES = 2 ** SET_IDX_W;

    typedef enum logic [OP_W-1:0] {
        OP_TOUCH = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

endpackage

/* hdl/clru_ram.sv */
// ----------------------------------------------------------------------------
// clru_ram: generic simple dual-port RAM
// One write port, one read port, registered read, old data on collision.
// ----------------------------------------------------------------------------
module clru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/cache_true_lru_replacement_core.sv */
// ----------------------------------------------------------------------------
// cache_true_lru_replacement_core: true-LRU way order for a set-assoc cache
// Per-set recency list in RAM, read-modify-write with one-deep forwarding.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream carries one request per beat: tuser[0] is the operation
//   (touch or query), tdata holds set_index, way and line_valid. A touch with
//   line_valid high makes the way most recent; with line_valid low it makes
//   the way least recent (next victim). A query leaves the order alone.
//   Master stream returns one beat per request: the victim way (head of the
//   set's list after the update), in request order.
// Timing
//   One request per cycle when not stalled. The result goes from stage 1
//   into the output register. The set row is read from RAM at accept time
//   and written back from stage 1; a back-to-back request to the same set
//   picks up the just-written row from a forwarding register.
// Reset
//   After i_rst_n is released the core sweeps the order RAM, one set per
//   cycle, writing 0,1,..,WAYS-1 into every row, with s_axis_tready low.
//   Requests are taken once the sweep is done.
// Stall
//   When m_axis_tready is low with a result pending, the whole pipe holds
//   and s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module cache_true_lru_replacement_core #(
    parameter int WAYS = 4,
    parameter int SETS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave request stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [5:0] set_index, [7:6] way, [8] line_valid, [15:9] zero
    input  logic [clru_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] operation
    input  logic [clru_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // master result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [1:0] victim_way, [7:2] zero
    output logic [clru_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import clru_pkg::*;

    // ------------------------------------------------------------------
    // derived sizes
    // ------------------------------------------------------------------
    localparam int WAY_W  = $clog2(WAYS);
    localparam int ROW_W  = WAYS * WAY_W;
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int CMP_W  = (WAY_W > WAY_IN_W) ? WAY_W : WAY_IN_W;
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);

    // set_index -> row address (wraps when SETS is below the index range)
    function automatic logic [IDX_CODES*SET_W-1:0] f_set_map();
        logic [IDX_CODES*SET_W-1:0] m;
        m = '0;
        for (int i = 0; i < IDX_CODES; i++) begin
            m[i*SET_W +: SET_W] = SET_W'(i % SETS);
        end
        return m;
    endfunction

    // reset row: position i holds way i
    function automatic logic [ROW_W-1:0] f_init_row();
        logic [ROW_W-1:0] r;
        r = '0;
        for (int i = 0; i < WAYS; i++) begin
            r[i*WAY_W +: WAY_W] = WAY_W'(i);
        end
        return r;
    endfunction

    localparam logic [IDX_CODES*SET_W-1:0] SET_MAP  = f_set_map();
    localparam logic [ROW_W-1:0]           INIT_ROW = f_init_row();

    // ------------------------------------------------------------------
    // request decode and handshake
    // ------------------------------------------------------------------
    logic                 adv;
    logic                 in_acc;
    logic [SET_IDX_W-1:0] in_idx;
    logic [SET_W-1:0]     in_set;

    logic                 r_clr_busy;
    logic [SET_W-1:0]     r_clr_idx;

    logic                 r_s1_vld;
    logic [SET_W-1:0]     r_s1_set;
    t_op                  r_s1_op;
    logic [WAY_IN_W-1:0]  r_s1_way;
    logic                 r_s1_lv;

    logic                 r_fwd_vld;
    logic [SET_W-1:0]     r_fwd_set;
    logic [ROW_W-1:0]     r_fwd_row;

    logic                 r_out_vld;
    logic [VICTIM_W-1:0]  r_out_victim;

    // pipe moves whenever the output register is free or being drained
    assign adv           = !r_out_vld || m_axis_tready;
    assign s_axis_tready = adv && !r_clr_busy;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_idx        = s_axis_tdata[SET_LSB +: SET_IDX_W];
    assign in_set        = SET_MAP[in_idx*SET_W +: SET_W];

    // ------------------------------------------------------------------
    // order RAM
    // ------------------------------------------------------------------
    logic             ram_we;
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] n_row;

    assign ram_we    = r_clr_busy || (adv && r_s1_vld && (r_s1_op == OP_TOUCH));
    assign ram_waddr = r_clr_busy ? r_clr_idx : r_s1_set;
    assign ram_wdata = r_clr_busy ? INIT_ROW : n_row;

    clru_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (in_set),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // stage 1: reorder the row
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]    cur_row;
    logic [WAY_W-1:0]    ent [WAYS];
    logic [WAY_W-1:0]    nxt [WAYS];
    logic [WAYS-1:0]     hit;
    logic [WAYS-1:0]     at_or_after;   // hit at this position or below it
    logic [WAYS-1:0]     at_or_before;  // hit at this position or above it
    logic                found;
    logic                do_move;
    logic [VICTIM_W-1:0] n_victim;

    // previous request wrote this set on the edge that read it
    assign cur_row = (r_fwd_vld && (r_fwd_set == r_s1_set)) ? r_fwd_row : ram_rdata;

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            ent[i] = cur_row[i*WAY_W +: WAY_W];
            hit[i] = (CMP_W'(ent[i]) == CMP_W'(r_s1_way));
        end
        found   = |hit;
        do_move = (r_s1_op == OP_TOUCH) && found;

        for (int i = 0; i < WAYS; i++) begin
            at_or_after[i]  = 1'b0;
            at_or_before[i] = 1'b0;
            for (int j = 0; j < WAYS; j++) begin
                if (j <= i) begin
                    at_or_after[i] = at_or_after[i] | hit[j];
                end
                if (j >= i) begin
                    at_or_before[i] = at_or_before[i] | hit[j];
                end
            end
        end

        for (int i = 0; i < WAYS; i++) begin
            nxt[i] = ent[i];
        end

        if (do_move) begin
            if (r_s1_lv) begin
                // to most-recent end: entries past the hole shift down
                for (int i = 0; i < WAYS - 1; i++) begin
                    if (at_or_after[i]) begin
                        nxt[i] = ent[i+1];
                    end
                end
                nxt[WAYS-1] = WAY_W'(r_s1_way);
            end else begin
                // to the victim slot: entries before the hole shift up
                for (int i = 1; i < WAYS; i++) begin
                    if (at_or_before[i]) begin
                        nxt[i] = ent[i-1];
                    end
                end
                nxt[0] = WAY_W'(r_s1_way);
            end
        end

        for (int i = 0; i < WAYS; i++) begin
            n_row[i*WAY_W +: WAY_W] = nxt[i];
        end
        n_victim = VICTIM_W'(nxt[0]);
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_s1_vld   <= 1'b0;
            r_fwd_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == LAST_SET) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (adv) begin
                r_s1_vld  <= in_acc;
                r_fwd_vld <= r_s1_vld;
                r_out_vld <= r_s1_vld;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_set <= in_set;
            r_s1_op  <= t_op'(s_axis_tuser[0]);
            r_s1_way <= s_axis_tdata[WAY_LSB +: WAY_IN_W];
            r_s1_lv  <= s_axis_tdata[LV_BIT];
        end
        if (adv) begin
            r_fwd_set <= r_s1_set;
            r_fwd_row <= n_row;
        end
        if (adv && r_s1_vld) begin
            r_out_victim <= n_victim;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = M_TDATA_W'(r_out_victim);

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // sweep ends right after the last row
    a_clr_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_clr_busy && (r_clr_idx == LAST_SET)) |=> !r_clr_busy)
        else $error("order RAM sweep did not finish on last set");

    // no request is in flight while the RAM is being swept
    a_clr_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_s1_vld && !r_out_vld))
        else $error("request in flight during RAM sweep");

    // a request in stage 1 always reaches the output register
    a_s1_to_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && adv) |=> m_axis_tvalid)
        else $error("stage 1 request lost");

    // a drained result with nothing behind it leaves the output empty
    a_no_dup : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !r_s1_vld) |=> !m_axis_tvalid)
        else $error("result repeated");

endmodule

/* dv/cache_true_lru_replacement_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cache_true_lru_replacement_core_test: self-checking bench for the LRU core
// Touch and query requests go into the slave stream, from a directed opener
// and then random phases. A scoreboard keeps its own copy of every set's
// recency list and checks each victim way returned on the master stream,
// in order. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module cache_true_lru_replacement_core_test;

    import clru_pkg::*;

    localparam int N_WAYS     = 4;
    localparam int N_SETS     = 64;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_REQS  = 200;
    localparam int LONG_HOLD   = 64;     // cycles the sink refuses results once
    localparam int DRAIN_LIMIT = 20000;  // cycles allowed for the last results
    localparam int TAIL_CYCLES = 8;      // settle time after the last result

    // ------------------------------------------------------------------------
    // Scoreboard: private copy of the recency lists plus the victims owed
    // ------------------------------------------------------------------------
    class victim_checker;
        int unsigned lru_list [N_SETS][N_WAYS];  // [0] is least recent
        bit [VICTIM_W-1:0] victims_owed [$];
        int unsigned failures;
        int unsigned results_seen;
        int unsigned touches, invalidations, queries;
        bit set_seen [IDX_CODES];

        function new();
            for (int s = 0; s < N_SETS; s++)
                for (int i = 0; i < N_WAYS; i++)
                    lru_list[s][i] = i;
            failures = 0;
            results_seen = 0;
            touches = 0;
            invalidations = 0;
            queries = 0;
        endfunction

        // Update the list of one set for a touch and return its head.
        function bit [VICTIM_W-1:0] predict_victim(t_op op, bit [SET_IDX_W-1:0] set_idx,
                                                   bit [WAY_IN_W-1:0] way, bit line_valid);
            int unsigned row;
            int unsigned pos;
            row = set_idx % N_SETS;
            if (op == OP_TOUCH) begin
                pos = N_WAYS;
                for (int i = 0; i < N_WAYS; i++)
                    if (pos == N_WAYS && lru_list[row][i] == way)
                        pos = i;
                // a way the set does not have leaves the order alone
                if (pos < N_WAYS) begin
                    if (line_valid) begin
                        for (int i = pos; i + 1 < N_WAYS; i++)
                            lru_list[row][i] = lru_list[row][i + 1];
                        lru_list[row][N_WAYS - 1] = way;
                    end else begin
                        for (int i = pos; i > 0; i--)
                            lru_list[row][i] = lru_list[row][i - 1];
                        lru_list[row][0] = way;
                    end
                end
            end
            return lru_list[row][0][VICTIM_W-1:0];
        endfunction

        function void note_request(logic [S_TDATA_W-1:0] tdata, logic [S_TUSER_W-1:0] tuser);
            t_op op;
            bit [SET_IDX_W-1:0] set_idx;
            bit [WAY_IN_W-1:0] way;
            bit line_valid;
            op         = t_op'(tuser[0]);
            set_idx    = tdata[SET_LSB +: SET_IDX_W];
            way        = tdata[WAY_LSB +: WAY_IN_W];
            line_valid = tdata[LV_BIT];
            set_seen[set_idx] = 1'b1;
            if (op == OP_QUERY)
                queries++;
            else if (line_valid)
                touches++;
            else
                invalidations++;
            victims_owed.insert(victims_owed.size(),
                                predict_victim(op, set_idx, way, line_valid));
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata);
            bit [VICTIM_W-1:0] want;
            results_seen++;
            if (victims_owed.size() == 0) begin
                $display("%0t ns: result with nothing pending, got victim %0d (tdata %h)",
                         $time, tdata[VICTIM_W-1:0], tdata);
                failures++;
                return;
            end
            want = victims_owed.pop_front();
            if (tdata[VICTIM_W-1:0] !== want) begin
                $display("%0t ns: victim_way mismatch, expected %0d, got %0d (tdata %h)",
                         $time, want, tdata[VICTIM_W-1:0], tdata);
                failures++;
            end
        endfunction

        function int unsigned pending();
            return victims_owed.size();
        endfunction

        function int unsigned sets_covered();
            int unsigned n;
            n = 0;
            foreach (set_seen[i])
                if (set_seen[i])
                    n++;
            return n;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // [5:0] set_index, [7:6] way, [8] line_valid
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;   // [0] operation
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // [1:0] victim_way

    victim_checker sb = new();

    // sink and source control, written by the main sequence
    bit sink_stalls_on = 1'b0;
    bit sink_hold_req  = 1'b0;
    bit src_gaps_on    = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    cache_true_lru_replacement_core #(
        .WAYS(N_WAYS),
        .SETS(N_SETS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned gap_length();
        if ($urandom_range(0, 19) < 16)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: handshakes are sampled at the edge, values are pre-edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)
            sb.note_request(s_axis_tdata, s_axis_tuser);
        if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            sb.check_result(m_axis_tdata);
    end

    // ------------------------------------------------------------------------
    // Result sink: random back-pressure, plus one long hold on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                hold = LONG_HOLD;
            end else if (hold == 0 && sink_stalls_on && $urandom_range(0, 4) == 0) begin
                hold = gap_length();
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request driver. tvalid is left high after a request so the next one
    // can follow back-to-back; src_idle drops it.
    // ------------------------------------------------------------------------
    task automatic send_request(t_op op, bit [SET_IDX_W-1:0] set_idx,
                                bit [WAY_IN_W-1:0] way, bit line_valid);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[SET_LSB +: SET_IDX_W] = set_idx;
        word[WAY_LSB +: WAY_IN_W]  = way;
        word[LV_BIT]               = line_valid;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
    endtask

    task automatic src_idle(int unsigned cycles);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= S_TDATA_W'($urandom());
        s_axis_tuser  <= S_TUSER_W'($urandom());
        repeat (cycles) @(posedge i_clk);
    endtask

    // random gap before a request, only when gaps are enabled for the phase
    task automatic maybe_idle();
        if (src_gaps_on && $urandom_range(0, 3) == 0)
            src_idle(gap_length());
    endtask

    // sender waits for every owed victim before going on
    task automatic drain_results();
        src_idle(0);
        while (sb.pending() > 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        bit narrow_sets;
        bit [SET_IDX_W-1:0] set_base;
        bit [SET_IDX_W-1:0] set_idx;
        t_op op;
        int unsigned drain_cycles;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opener. Fresh sets must report way 0; then moves to either
        // end, touches of a way already in place, queries carrying junk in
        // way/line_valid, and back-to-back hits on one set (forwarding path).
        send_request(OP_QUERY, 6'd0,  2'd3, 1'b1);
        send_request(OP_QUERY, 6'd63, 2'd0, 1'b0);
        send_request(OP_TOUCH, 6'd0,  2'd0, 1'b1);   // victim -> 1
        send_request(OP_TOUCH, 6'd0,  2'd3, 1'b1);
        send_request(OP_TOUCH, 6'd0,  2'd3, 1'b1);   // already most recent
        send_request(OP_TOUCH, 6'd0,  2'd2, 1'b0);   // invalidate: victim -> 2
        send_request(OP_TOUCH, 6'd0,  2'd2, 1'b0);   // already least recent
        send_request(OP_QUERY, 6'd0,  2'd1, 1'b0);
        send_request(OP_TOUCH, 6'd63, 2'd3, 1'b0);   // tail to head
        send_request(OP_TOUCH, 6'd63, 2'd3, 1'b1);   // head to tail
        send_request(OP_TOUCH, 6'd63, 2'd1, 1'b0);   // middle to head
        send_request(OP_TOUCH, 6'd63, 2'd0, 1'b1);
        send_request(OP_QUERY, 6'd63, 2'd3, 1'b1);
        send_request(OP_TOUCH, 6'd1,  2'd0, 1'b1);   // rotate set 1 fully
        send_request(OP_TOUCH, 6'd1,  2'd1, 1'b1);
        send_request(OP_TOUCH, 6'd1,  2'd2, 1'b1);
        send_request(OP_TOUCH, 6'd1,  2'd3, 1'b1);   // back to 0,1,2,3
        send_request(OP_TOUCH, 6'd42, 2'd1, 1'b1);
        send_request(OP_TOUCH, 6'd21, 2'd2, 1'b0);   // alternate two sets
        send_request(OP_TOUCH, 6'd42, 2'd0, 1'b1);
        send_request(OP_TOUCH, 6'd21, 2'd1, 1'b1);
        send_request(OP_QUERY, 6'd42, 2'd2, 1'b0);
        send_request(OP_QUERY, 6'd21, 2'd0, 1'b1);
        drain_results();

        // Random phases. Narrow phases hammer a handful of sets so the lists
        // get deep reordering and frequent same-set back-to-back traffic;
        // wide phases spread over every set index.
        for (int p = 0; p < RAND_PHASES; p++) begin
            narrow_sets    = (p % 2 == 0);
            set_base       = SET_IDX_W'($urandom());
            src_gaps_on    = (p % 3 != 0);
            sink_stalls_on = (p % 4 != 1);
            // one phase opens with a long sink hold while requests keep coming
            if (p == 2) begin
                src_gaps_on   = 1'b0;
                sink_hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_REQS; n++) begin
                maybe_idle();
                if (narrow_sets)
                    set_idx = SET_IDX_W'(set_base + $urandom_range(0, 3));
                else
                    set_idx = SET_IDX_W'($urandom());
                op = ($urandom_range(0, 4) == 0) ? OP_QUERY : OP_TOUCH;
                send_request(op, set_idx, WAY_IN_W'($urandom()),
                             $urandom_range(0, 9) < 7);
            end
            drain_results();
        end

        // Wind down: everything accepted, wait out the owed results.
        src_idle(0);
        sink_stalls_on = 1'b0;
        drain_cycles = 0;
        while (sb.pending() > 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() > 0) begin
            $display("%0t ns: %0d victim results never arrived", $time, sb.pending());
            sb.failures++;
        end

        $display("Covered %0d requests: %0d accesses, %0d invalidations, %0d queries.",
                 sb.results_seen, sb.touches, sb.invalidations, sb.queries);
        $display("Set indexes used: %0d of %0d, with random stalls on both streams.",
                 sb.sets_covered(), IDX_CODES);
        if (sb.failures == 0)
            $display("** cache_true_lru_replacement_core: PASSED **");
        else
            $display("** cache_true_lru_replacement_core: FAILED **");
        $finish;
    end

    // Watchdog, set far beyond the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("%0t ns: run timed out", $time);
        $display("** cache_true_lru_replacement_core: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
hdl/clru_pkg.sv
hdl/clru_ram.sv
hdl/cache_true_lru_replacement_core.sv
dv/cache_true_lru_replacement_core_test.sv
